// ----- sv/i2cme_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package i2cme_pkg;

    localparam int OPCODE_W  = 2;
    localparam int BYTE_W    = 8;
    localparam int TICKS_W   = 8;
    localparam int LIMIT_W   = 10;
    localparam int PHASE_W   = 4;
    localparam int BIT_IDX_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [TICKS_W-1:0] PHASE_TICKS_RST    = 8'd1;
    localparam logic [TICKS_W-1:0] ACK_HIGH_TICKS_RST = 8'd10;
    localparam logic [LIMIT_W-1:0] BUSY_LIMIT_RST     = 10'd500;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_HIGH_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUSY_LIMIT     = 2'd2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        PIN_NONE = 2'd0,
        PIN_SCL  = 2'd1,
        PIN_SDA  = 2'd2
    } t_pin;

    typedef struct packed {
        logic [TICKS_W-1:0] phase_ticks;
        logic [TICKS_W-1:0] ack_high_ticks;
        logic [LIMIT_W-1:0] busy_limit;
    } t_cfg;

    typedef struct packed {
        logic              scl_out;
        logic              sda_out;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              nack_seen;
        logic              bus_timeout;
    } t_result;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [LIMIT_W-1:0] count;
        logic               timeout;
    } t_recover;

endpackage

`default_nettype wire

// ----- sv/i2cme_cmd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface i2cme_cmd_if;
    import i2cme_pkg::*;

    logic                valid;
    logic                ready;
    logic                cmd_valid;
    logic [OPCODE_W-1:0] opcode;
    logic [BYTE_W-1:0]   tx_byte;
    logic                send_nack;
    logic                sda_in;

    modport source (output valid, cmd_valid, opcode, tx_byte, send_nack, sda_in,
                    input ready);
    modport sink (input valid, cmd_valid, opcode, tx_byte, send_nack, sda_in,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/i2cme_res_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface i2cme_res_if;
    import i2cme_pkg::*;

    logic              valid;
    logic              ready;
    logic              scl_out;
    logic              sda_out;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              nack_seen;
    logic              bus_timeout;

    modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte,
                    nack_seen, bus_timeout, input ready);
    modport sink (input valid, scl_out, sda_out, busy_res, done_res, rx_byte,
                  nack_seen, bus_timeout, output ready);
endinterface

`default_nettype wire

// ----- sv/i2cme_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module i2cme_cfg_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [i2cme_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [i2cme_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output i2cme_pkg::t_cfg                        o_cfg
);
    import i2cme_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PHASE_TICKS:    n_cfg.phase_ticks    = i_cfg_data[TICKS_W-1:0];
                CFG_ACK_HIGH_TICKS: n_cfg.ack_high_ticks = i_cfg_data[TICKS_W-1:0];
                CFG_BUSY_LIMIT:     n_cfg.busy_limit     = i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_ticks    <= PHASE_TICKS_RST;
            r_cfg.ack_high_ticks <= ACK_HIGH_TICKS_RST;
            r_cfg.busy_limit     <= BUSY_LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- sv/i2cme_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module i2cme_seq (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  i2cme_pkg::t_cfg                      i_cfg,
    input  wire logic                            i_step,
    input  wire logic                            i_cmd_valid,
    input  wire logic [i2cme_pkg::OPCODE_W-1:0]  i_opcode,
    input  wire logic [i2cme_pkg::BYTE_W-1:0]    i_tx_byte,
    input  wire logic                            i_send_nack,
    input  wire logic                            i_sda_in,
    output i2cme_pkg::t_result                   o_next
);
    import i2cme_pkg::*;

    t_opcode              r_cmd, n_cmd;
    logic                 r_running, n_running;
    logic                 r_nack_choice, n_nack_choice;
    logic [PHASE_W-1:0]   r_phase, n_phase;
    logic [TICKS_W-1:0]   r_hold, n_hold;
    logic [BIT_IDX_W-1:0] r_bit_idx, n_bit_idx;
    logic [BYTE_W-1:0]    r_shift, n_shift;
    logic [LIMIT_W-1:0]   r_recover, n_recover;
    logic                 r_scl, n_scl;
    logic                 r_sda, n_sda;
    logic                 r_nack, n_nack;
    logic                 r_timeout, n_timeout;
    logic [BYTE_W-1:0]    r_rx, n_rx;

    t_opcode              w_op;
    t_recover             w_rec_accept;
    t_recover             w_rec_run;
    logic [LIMIT_W-1:0]   w_rc_start;
    t_pin                 w_pin;
    logic                 w_val;
    logic                 w_long;
    logic                 w_last;
    logic [TICKS_W-1:0]   w_dur;
    logic                 w_hold_more;
    logic [BIT_IDX_W-1:0] w_bit_next;
    logic [PHASE_W-1:0]   w_next_phase;
    logic                 w_done;

    function automatic t_recover recover_step(input logic sda,
                                              input logic [LIMIT_W-1:0] count);
        t_recover res;
        res.phase   = 4'd2;
        res.count   = count;
        res.timeout = 1'b0;
        if (!sda) begin
            if (count <= 10'd1) begin
                res.count   = '0;
                res.timeout = 1'b1;
            end else begin
                res.count = count - 10'd1;
                res.phase = 4'd0;
            end
        end
        return res;
    endfunction

    assign w_op         = t_opcode'(i_opcode);
    assign w_rc_start   = (i_cfg.busy_limit != '0) ? i_cfg.busy_limit : 10'd1;
    assign w_rec_accept = recover_step(i_sda_in, w_rc_start);
    assign w_rec_run    = recover_step(i_sda_in, r_recover);
    assign w_bit_next   = r_bit_idx + 4'd1;

    // Pin step table for the current command and phase.
    always_comb begin
        w_pin  = PIN_NONE;
        w_val  = 1'b0;
        w_long = 1'b0;
        w_last = 1'b0;
        case (r_cmd)
            OP_START: begin
                case (r_phase)
                    4'd0: begin w_pin = PIN_SCL; w_val = 1'b0; end
                    4'd1: begin w_pin = PIN_SCL; w_val = 1'b1; end
                    4'd2: begin w_pin = PIN_SCL; w_val = 1'b0; end
                    4'd3: begin w_pin = PIN_SDA; w_val = 1'b1; end
                    4'd4: begin w_pin = PIN_SCL; w_val = 1'b1; end
                    4'd5: begin w_pin = PIN_SDA; w_val = 1'b0; end
                    4'd6: begin w_pin = PIN_SCL; w_val = 1'b0; w_last = 1'b1; end
                    default: w_last = 1'b1;
                endcase
            end
            OP_STOP: begin
                case (r_phase)
                    4'd0: begin w_pin = PIN_SCL; w_val = 1'b0; end
                    4'd1: begin w_pin = PIN_SDA; w_val = 1'b0; end
                    4'd2: begin w_pin = PIN_SCL; w_val = 1'b1; end
                    4'd3: begin w_pin = PIN_SDA; w_val = 1'b1; w_last = 1'b1; end
                    default: w_last = 1'b1;
                endcase
            end
            OP_WRITE: begin
                case (r_phase)
                    4'd0: begin w_pin = PIN_SCL; w_val = 1'b0; end
                    4'd1: begin w_pin = PIN_SDA; w_val = r_shift[BYTE_W-1]; end
                    4'd2: begin w_pin = PIN_SCL; w_val = 1'b1; end
                    4'd3: begin w_pin = PIN_SCL; w_val = 1'b0; end
                    4'd4: begin w_pin = PIN_SDA; w_val = 1'b1; end
                    4'd5: begin w_pin = PIN_SCL; w_val = 1'b0; end
                    4'd6: begin w_pin = PIN_SDA; w_val = 1'b1; end
                    4'd7: begin w_pin = PIN_SCL; w_val = 1'b1; w_long = 1'b1; end
                    4'd8: begin w_pin = PIN_SCL; w_val = 1'b0; end
                    4'd9: begin w_pin = PIN_SDA; w_val = 1'b1; w_last = 1'b1; end
                    default: w_last = 1'b1;
                endcase
            end
            default: begin
                case (r_phase)
                    4'd0: begin w_pin = PIN_SCL; w_val = 1'b1; end
                    4'd1: begin w_pin = PIN_SCL; w_val = 1'b0; end
                    4'd2: begin w_pin = PIN_SCL; w_val = 1'b0; end
                    4'd3: begin w_pin = PIN_SDA; w_val = r_nack_choice; end
                    4'd4: begin w_pin = PIN_SCL; w_val = 1'b1; w_long = 1'b1; end
                    4'd5: begin w_pin = PIN_SCL; w_val = 1'b0; end
                    4'd6: begin w_pin = PIN_SDA; w_val = 1'b1; w_last = 1'b1; end
                    default: w_last = 1'b1;
                endcase
            end
        endcase
    end

    always_comb begin
        w_dur = w_long ? i_cfg.ack_high_ticks : i_cfg.phase_ticks;
        if (w_dur == '0) begin
            w_dur = 8'd1;
        end
    end

    assign w_hold_more = ({1'b0, r_hold} + 9'd1) < {1'b0, w_dur};

    always_comb begin
        n_cmd         = r_cmd;
        n_running     = r_running;
        n_nack_choice = r_nack_choice;
        n_phase       = r_phase;
        n_hold        = r_hold;
        n_bit_idx     = r_bit_idx;
        n_shift       = r_shift;
        n_recover     = r_recover;
        n_scl         = r_scl;
        n_sda         = r_sda;
        n_nack        = r_nack;
        n_timeout     = r_timeout;
        n_rx          = r_rx;
        w_done        = 1'b0;
        w_next_phase  = r_phase + 4'd1;

        if (i_step) begin
            if (!r_running) begin
                if (i_cmd_valid) begin
                    n_cmd         = w_op;
                    n_nack_choice = i_send_nack;
                    n_shift       = (w_op == OP_WRITE) ? i_tx_byte : '0;
                    n_nack        = 1'b0;
                    n_timeout     = 1'b0;
                    n_bit_idx     = '0;
                    n_hold        = '0;
                    n_running     = 1'b1;
                    n_phase       = '0;
                    if (w_op == OP_START) begin
                        n_recover = w_rec_accept.count;
                        n_phase   = w_rec_accept.phase;
                        n_timeout = w_rec_accept.timeout;
                    end
                end
            end else begin
                case (w_pin)
                    PIN_SCL: n_scl = w_val;
                    PIN_SDA: n_sda = w_val;
                    default: ;
                endcase
                if (w_pin == PIN_NONE) begin
                    n_running = 1'b0;
                    w_done    = 1'b1;
                end else if (w_hold_more) begin
                    n_hold = r_hold + 8'd1;
                end else begin
                    n_hold = '0;
                    case (r_cmd)
                        OP_START: begin
                            if (r_phase == 4'd1) begin
                                n_recover    = w_rec_run.count;
                                w_next_phase = w_rec_run.phase;
                                n_timeout    = r_timeout | w_rec_run.timeout;
                            end
                        end
                        OP_WRITE: begin
                            if (r_phase == 4'd1) begin
                                n_shift = {r_shift[BYTE_W-2:0], 1'b0};
                            end
                            if (r_phase == 4'd2) begin
                                n_bit_idx    = w_bit_next;
                                w_next_phase = (w_bit_next < 4'd8) ? 4'd0 : 4'd3;
                            end
                            if (r_phase == 4'd7) begin
                                n_nack = i_sda_in;
                            end
                        end
                        OP_READ: begin
                            if (r_phase == 4'd0) begin
                                n_shift = {r_shift[BYTE_W-2:0], i_sda_in};
                            end
                            if (r_phase == 4'd1) begin
                                n_bit_idx    = w_bit_next;
                                w_next_phase = (w_bit_next < 4'd8) ? 4'd0 : 4'd2;
                            end
                            if (w_last) begin
                                n_rx = n_shift;
                            end
                        end
                        default: ;
                    endcase
                    if (w_last) begin
                        n_running = 1'b0;
                        w_done    = 1'b1;
                    end else begin
                        n_phase = w_next_phase;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd         <= OP_START;
            r_running     <= 1'b0;
            r_nack_choice <= 1'b0;
            r_phase       <= '0;
            r_hold        <= '0;
            r_bit_idx     <= '0;
            r_shift       <= '0;
            r_recover     <= '0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_nack        <= 1'b0;
            r_timeout     <= 1'b0;
            r_rx          <= '0;
        end else begin
            r_cmd         <= n_cmd;
            r_running     <= n_running;
            r_nack_choice <= n_nack_choice;
            r_phase       <= n_phase;
            r_hold        <= n_hold;
            r_bit_idx     <= n_bit_idx;
            r_shift       <= n_shift;
            r_recover     <= n_recover;
            r_scl         <= n_scl;
            r_sda         <= n_sda;
            r_nack        <= n_nack;
            r_timeout     <= n_timeout;
            r_rx          <= n_rx;
        end
    end

    assign o_next.scl_out     = n_scl;
    assign o_next.sda_out     = n_sda;
    assign o_next.busy_res    = n_running;
    assign o_next.done_res    = w_done;
    assign o_next.rx_byte     = n_rx;
    assign o_next.nack_seen   = n_nack;
    assign o_next.bus_timeout = n_timeout;

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> r_phase <= 4'd9)
        else $error("sequence phase out of range");

    a_hold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> r_hold < 8'd255)
        else $error("hold counter overran the longest phase");

    a_timeout_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_timeout) |-> r_cmd == OP_START)
        else $error("bus timeout raised outside a start command");

endmodule

`default_nettype wire

// ----- sv/i2c_master_byte_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Each accepted transaction is one bus tick; its result is registered, offered the next cycle.
// One tick per cycle while result side stays ready, set by the per-tick sequencer state update.
// A new tick is taken whenever the result register is empty or being emptied in the same cycle.
// Synchronous active-low reset releases sequencer pins and status and loads register defaults.
module i2c_master_byte_engine (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    i2cme_cmd_if.sink                              i_cmd,
    i2cme_res_if.source                            o_res,
    input  wire logic                              i_cfg_we,
    input  wire logic [i2cme_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [i2cme_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import i2cme_pkg::*;

    t_cfg    w_cfg;
    t_result w_next;
    logic    w_ready;
    logic    w_step;
    logic    r_out_valid, n_out_valid;
    t_result r_res;

    i2cme_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    i2cme_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_step      (w_step),
        .i_cmd_valid (i_cmd.cmd_valid),
        .i_opcode    (i_cmd.opcode),
        .i_tx_byte   (i_cmd.tx_byte),
        .i_send_nack (i_cmd.send_nack),
        .i_sda_in    (i_cmd.sda_in),
        .o_next      (w_next)
    );

    assign w_ready     = !r_out_valid || o_res.ready;
    assign w_step      = i_cmd.valid && w_ready;
    assign i_cmd.ready = w_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_step) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_res <= w_next;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.scl_out     = r_res.scl_out;
    assign o_res.sda_out     = r_res.sda_out;
    assign o_res.busy_res    = r_res.busy_res;
    assign o_res.done_res    = r_res.done_res;
    assign o_res.rx_byte     = r_res.rx_byte;
    assign o_res.nack_seen   = r_res.nack_seen;
    assign o_res.bus_timeout = r_res.bus_timeout;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.done_res |-> !r_res.busy_res)
        else $error("completed command still reported busy");

    a_step_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("accepted tick produced no result");

    a_done_needs_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_step |-> !w_next.done_res)
        else $error("completion signalled without an accepted tick");

endmodule

`default_nettype wire
